/* sv/fpfa_pkg.sv */
package fpfa_pkg;

   // fixed field widths
   localparam int SLOT_W   = 4;
   localparam int AMOUNT_W = 16;
   localparam int CSR_W    = 5;
   localparam int CSR_IDX_W = 1;

   // command codes
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_ALLOC = 1'b1;

   // placement rules; the unused code acts as first fit
   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIT_MODE    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT = 1'd1;

   localparam logic [1:0] FIT_MODE_RESET    = FIT_FIRST;
   localparam logic [4:0] BLOCK_COUNT_RESET = 5'd16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_DELIVER
   } state_type;

   typedef struct packed {
      logic load_wr;
      logic alloc_start;
      logic issue;
      logic update;
      logic deliver;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_done;
   } dp_status_type;

endpackage

/* sv/fpfa_if.sv */
interface fpfa_req_if;
   import fpfa_pkg::*;
   logic                valid;
   logic                ready;
   logic                command;
   logic [SLOT_W-1:0]   slot;
   logic [AMOUNT_W-1:0] amount;

   modport source (output valid, command, slot, amount, input ready);
   modport sink   (input valid, command, slot, amount, output ready);
endinterface

interface fpfa_rsp_if;
   import fpfa_pkg::*;
   logic                valid;
   logic                ready;
   logic                granted;
   logic [SLOT_W-1:0]   chosen_slot;
   logic [AMOUNT_W-1:0] chosen_block_size;
   logic [AMOUNT_W-1:0] request_echo;
   logic [AMOUNT_W-1:0] capacity_left;

   modport source (output valid, granted, chosen_slot, chosen_block_size, request_echo,
                   capacity_left, input ready);
   modport sink   (input valid, granted, chosen_slot, chosen_block_size, request_echo,
                   capacity_left, output ready);
endinterface

/* sv/fpfa_ctrl.sv */
module fpfa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_command,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output fpfa_pkg::dp_cmd_type    cmd,
   input  fpfa_pkg::dp_status_type status
);
   import fpfa_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_command == CMD_LOAD) begin
                  cmd.load_wr = 1'b1;
               end else begin
                  cmd.alloc_start = 1'b1;
                  state_in        = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_UPDATE;
            end else begin
               cmd.issue = 1'b1;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_DELIVER;
         end
         ST_DELIVER: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.deliver = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.deliver) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // at most one datapath command at a time
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_wr, cmd.alloc_start, cmd.issue, cmd.update, cmd.deliver}))
      else $error("more than one datapath command");

   // a pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.deliver |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before taken");

   // the scan only issues reads while entries remain
   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> !status.scan_done)
      else $error("read issued past scan limit");

endmodule

/* sv/fpfa_datapath.sv */
module fpfa_datapath #(
   parameter int NUM_BLOCKS = 16,
   parameter int SIZE_BITS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [fpfa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fpfa_pkg::CSR_W-1:0]           csr_wdata,
   input  logic [fpfa_pkg::SLOT_W-1:0]          req_slot,
   input  logic [fpfa_pkg::AMOUNT_W-1:0]        req_amount,
   input  fpfa_pkg::dp_cmd_type                 cmd,
   output fpfa_pkg::dp_status_type              status,
   output logic                                 rsp_granted,
   output logic [fpfa_pkg::SLOT_W-1:0]          rsp_chosen_slot,
   output logic [fpfa_pkg::AMOUNT_W-1:0]        rsp_chosen_block_size,
   output logic [fpfa_pkg::AMOUNT_W-1:0]        rsp_request_echo,
   output logic [fpfa_pkg::AMOUNT_W-1:0]        rsp_capacity_left
);
   import fpfa_pkg::*;

   localparam int IDX_BITS = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CNT_BITS = $clog2(NUM_BLOCKS + 1);
   localparam int CMP_BITS = (CNT_BITS > CSR_W) ? CNT_BITS : CSR_W;

   // configuration
   logic [1:0]       fit_mode_ff;
   logic [CSR_W-1:0] block_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff    <= FIT_MODE_RESET;
         block_count_ff <= BLOCK_COUNT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FIT_MODE:    fit_mode_ff    <= csr_wdata[1:0];
            CSR_BLOCK_COUNT: block_count_ff <= csr_wdata;
            default:         ;
         endcase
      end
   end

   // block table
   logic [SIZE_BITS-1:0] orig_mem [NUM_BLOCKS];
   logic [SIZE_BITS-1:0] cap_mem  [NUM_BLOCKS];

   logic                 slot_ok;
   logic [IDX_BITS-1:0]  load_idx;
   logic [SIZE_BITS-1:0] load_amount;

   assign slot_ok     = 32'(req_slot) < NUM_BLOCKS;
   assign load_idx    = IDX_BITS'(req_slot);
   assign load_amount = SIZE_BITS'(req_amount);

   // scan state
   logic [CNT_BITS-1:0]  cnt_ff;
   logic                 rd_valid_ff;
   logic [IDX_BITS-1:0]  rd_idx_ff;
   logic [SIZE_BITS-1:0] rd_cap_ff;
   logic [SIZE_BITS-1:0] amount_ff;
   logic                 found_ff;
   logic [IDX_BITS-1:0]  pick_ff;
   logic [SIZE_BITS-1:0] best_cap_ff;
   logic [SIZE_BITS-1:0] orig_rd_ff;
   logic [SIZE_BITS-1:0] left_ff;
   logic [SIZE_BITS-1:0] left_in;
   logic                 fits;
   logic                 take;

   assign left_in = best_cap_ff - amount_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_wr && slot_ok) begin
         orig_mem[load_idx] <= load_amount;
      end
      if (cmd.update) begin
         orig_rd_ff <= orig_mem[pick_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_wr && slot_ok) begin
         cap_mem[load_idx] <= load_amount;
      end else if (cmd.update && found_ff) begin
         cap_mem[pick_ff] <= left_in;
      end
      if (cmd.issue) begin
         rd_cap_ff <= cap_mem[cnt_ff[IDX_BITS-1:0]];
      end
   end

   assign status.scan_done = (cnt_ff == CNT_BITS'(NUM_BLOCKS)) ||
                             (CMP_BITS'(cnt_ff) >= CMP_BITS'(block_count_ff));

   assign fits = amount_ff <= rd_cap_ff;
   always_comb begin
      take = 1'b0;
      if (rd_valid_ff && fits) begin
         if (!found_ff) begin
            take = 1'b1;
         end else if (fit_mode_ff == FIT_BEST) begin
            take = rd_cap_ff < best_cap_ff;
         end else if (fit_mode_ff == FIT_WORST) begin
            take = rd_cap_ff > best_cap_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         rd_valid_ff <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.issue;
         if (cmd.alloc_start) begin
            cnt_ff   <= '0;
            found_ff <= 1'b0;
         end else begin
            if (cmd.issue) begin
               cnt_ff <= cnt_ff + 1'b1;
            end
            if (take) begin
               found_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.alloc_start) begin
         amount_ff <= SIZE_BITS'(req_amount);
      end
      if (cmd.issue) begin
         rd_idx_ff <= cnt_ff[IDX_BITS-1:0];
      end
      if (take) begin
         pick_ff     <= rd_idx_ff;
         best_cap_ff <= rd_cap_ff;
      end
      if (cmd.update) begin
         left_ff <= left_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.deliver) begin
         rsp_granted      <= found_ff;
         rsp_request_echo <= AMOUNT_W'(amount_ff);
         if (found_ff) begin
            rsp_chosen_slot       <= SLOT_W'(pick_ff);
            rsp_chosen_block_size <= AMOUNT_W'(orig_rd_ff);
            rsp_capacity_left     <= AMOUNT_W'(left_ff);
         end else begin
            rsp_chosen_slot       <= '0;
            rsp_chosen_block_size <= '0;
            rsp_capacity_left     <= '0;
         end
      end
   end

   // a held candidate always fits the request
   a_pick_fits: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> amount_ff <= best_cap_ff)
      else $error("chosen block does not fit request");

   // a held candidate was among the entries already read
   a_pick_scanned: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> CNT_BITS'(pick_ff) < cnt_ff)
      else $error("chosen block beyond scanned range");

endmodule

/* sv/fixed_partition_fit_allocator_top.sv */
// channel   dir   handshake              payload
// req_if    in    valid/ready            command, slot, amount
// rsp_if    out   valid/ready            granted, chosen_slot, chosen_block_size,
//                                        request_echo, capacity_left
// csr_*     in    csr_wr_en, no stall    csr_index, csr_wdata
//
// a load transaction is taken in the idle state and produces no result
// an allocate transaction reads limit = min(block_count, NUM_BLOCKS) table entries in turn
// through the single capacity read port, with accept before the scan and end of scan,
// write-back and result load after it
// reset is synchronous; it clears the controller, result valid and scan state and resets
// the config registers; block table and result registers hold garbage until written
// a pending result stalls the next allocate at its result load; loads go on while idle
module fixed_partition_fit_allocator_top #(
   parameter int NUM_BLOCKS = 16,
   parameter int SIZE_BITS  = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   fpfa_req_if.sink                        req_if,
   fpfa_rsp_if.source                      rsp_if,
   input  logic                            csr_wr_en,
   input  logic [fpfa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fpfa_pkg::CSR_W-1:0]      csr_wdata
);
   import fpfa_pkg::*;

   // command and status between the sequencer and the table datapath
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // controller: accepts transactions, steps the scan, owns result valid
   fpfa_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_command (req_if.command),
      .req_ready   (req_if.ready),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .cmd         (dp_cmd),
      .status      (dp_status)
   );

   // datapath: config registers, block table, fit compare and result register
   fpfa_datapath #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .SIZE_BITS  (SIZE_BITS)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_slot              (req_if.slot),
      .req_amount            (req_if.amount),
      .cmd                   (dp_cmd),
      .status                (dp_status),
      .rsp_granted           (rsp_if.granted),
      .rsp_chosen_slot       (rsp_if.chosen_slot),
      .rsp_chosen_block_size (rsp_if.chosen_block_size),
      .rsp_request_echo      (rsp_if.request_echo),
      .rsp_capacity_left     (rsp_if.capacity_left)
   );

endmodule
